[hdl/running_max_xor_pair_core_macros.svh]
// ----------------------------------------------------------------------------
// running_max_xor_pair_core_macros
// assertion helpers used by the checker file of the block
// ----------------------------------------------------------------------------
`ifndef RUNNING_MAX_XOR_PAIR_CORE_MACROS_SVH
`define RUNNING_MAX_XOR_PAIR_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RMXP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define RMXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rmxp_pkg.sv]
// ----------------------------------------------------------------------------
// rmxp_pkg
// types and constants of the running max xor pair block
// ----------------------------------------------------------------------------
package rmxp_pkg;

  localparam int VALUE_W   = 32;
  localparam int MAX_XOR_W = 32;

  typedef logic [VALUE_W-1:0]   value_t;
  typedef logic [MAX_XOR_W-1:0] max_xor_t;

  // control that rides along with each beat through the cell chain
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic over;
  } rmxp_ctl_t;

endpackage

[hdl/rmxp_if.sv]
// ----------------------------------------------------------------------------
// rmxp_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface rmxp_in_if import rmxp_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   first;
  logic   last;

  modport source (output valid, output value, output first, output last, input ready);
  modport sink   (input valid, input value, input first, input last, output ready);
endinterface

interface rmxp_out_if import rmxp_pkg::*; ();
  logic     valid;
  logic     ready;
  max_xor_t max_xor;
  logic     overflow;
  logic     is_last;

  modport source (output valid, output max_xor, output overflow, output is_last,
                  input ready);
  modport sink   (input valid, input max_xor, input overflow, input is_last,
                  output ready);
endinterface

[hdl/running_max_xor_pair_core.sv]
// ----------------------------------------------------------------------------
// running_max_xor_pair_core
// running maximum xor over all pairs of the values of one array
// ----------------------------------------------------------------------------
// One input beat can be accepted in every cycle while the result side does not
// stall; each result passes the cell chain and then the output register. Each
// cell holds one stored value; a beat walks the chain one cell per cycle, writes
// itself into the cell of its own slot and picks up the xor with every older
// entry. A stall on the result side holds the whole chain and the input. Values
// beyond MAX_ENTRIES in one array are compared but not stored and come back
// with overflow set.
module running_max_xor_pair_core import rmxp_pkg::*; #(
  parameter int MAX_ENTRIES = 256,
  parameter int VALUE_BITS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmxp_in_if.sink    in_i,
  rmxp_out_if.source out_o
);

  localparam int DataW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int IdxW  = $clog2(MAX_ENTRIES + 1);
  localparam logic [IdxW-1:0] FullCnt = IdxW'(MAX_ENTRIES);

  logic             en;
  logic             accept;
  logic [IdxW-1:0]  cnt_q, cnt_d, base;
  logic             full;

  rmxp_ctl_t        ctl  [MAX_ENTRIES+1];
  logic [DataW-1:0] val  [MAX_ENTRIES+1];
  logic [IdxW-1:0]  idx  [MAX_ENTRIES+1];
  logic [DataW-1:0] pmax [MAX_ENTRIES+1];

  logic [DataW-1:0] best_q, best_d, merged;
  logic             out_valid_q;
  max_xor_t         out_max_q;
  logic             out_over_q, out_last_q;

  assign en     = !out_valid_q || out_o.ready;
  assign accept = in_i.valid && en;
  assign in_i.ready = en;

  // slot of the incoming value within its array
  assign base = in_i.first ? '0 : cnt_q;
  assign full = base == FullCnt;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = full ? base : base + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign ctl[0]  = '{valid: in_i.valid, first: in_i.first, last: in_i.last, over: full};
  assign val[0]  = in_i.value[DataW-1:0];
  assign idx[0]  = base;
  assign pmax[0] = '0;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    rmxp_cell #(
      .DataW  (DataW),
      .IdxW   (IdxW),
      .CellIdx(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctl_i (ctl[k]),
      .val_i (val[k]),
      .idx_i (idx[k]),
      .pmax_i(pmax[k]),
      .ctl_o (ctl[k+1]),
      .val_o (val[k+1]),
      .idx_o (idx[k+1]),
      .pmax_o(pmax[k+1])
    );
  end

  // fold the beat's own maximum into the running maximum of its array
  always_comb begin
    if (ctl[MAX_ENTRIES].first) begin
      merged = pmax[MAX_ENTRIES];
    end else if (pmax[MAX_ENTRIES] > best_q) begin
      merged = pmax[MAX_ENTRIES];
    end else begin
      merged = best_q;
    end
    best_d = best_q;
    if (en && ctl[MAX_ENTRIES].valid) begin
      best_d = merged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      best_q <= best_d;
      if (en) begin
        out_valid_q <= ctl[MAX_ENTRIES].valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_max_q  <= max_xor_t'(merged);
      out_over_q <= ctl[MAX_ENTRIES].over;
      out_last_q <= ctl[MAX_ENTRIES].last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.max_xor  = out_max_q;
  assign out_o.overflow = out_over_q;
  assign out_o.is_last  = out_last_q;

endmodule

[hdl/rmxp_cell.sv]
// ----------------------------------------------------------------------------
// rmxp_cell
// one chain cell: holds one stored value, writes it when the passing beat
// carries its slot, and folds the xor with older entries into the beat's max
// ----------------------------------------------------------------------------
module rmxp_cell import rmxp_pkg::*; #(
  parameter int DataW   = 32,
  parameter int IdxW    = 9,
  parameter int CellIdx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  rmxp_ctl_t        ctl_i,
  input  logic [DataW-1:0] val_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [DataW-1:0] pmax_i,
  output rmxp_ctl_t        ctl_o,
  output logic [DataW-1:0] val_o,
  output logic [IdxW-1:0]  idx_o,
  output logic [DataW-1:0] pmax_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic [DataW-1:0] stored_q;
  rmxp_ctl_t        ctl_q;
  logic [DataW-1:0] val_q, pmax_q, pmax_d;
  logic [IdxW-1:0]  idx_q;
  logic [DataW-1:0] xor_w;
  logic             older_w;

  // entries below the beat's slot belong to the same array and were written earlier
  assign older_w = idx_i > MyIdx;
  assign xor_w   = stored_q ^ val_i;

  always_comb begin
    pmax_d = pmax_i;
    if (older_w && (xor_w > pmax_i)) begin
      pmax_d = xor_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctl_i.valid && (idx_i == MyIdx)) begin
      stored_q <= val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q  <= val_i;
      idx_q  <= idx_i;
      pmax_q <= pmax_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign val_o  = val_q;
  assign idx_o  = idx_q;
  assign pmax_o = pmax_q;

endmodule

[hdl/rmxp_checker.sv]
// ----------------------------------------------------------------------------
// rmxp_checker
// port-level checks of the running max xor pair block, bound to the top
// ----------------------------------------------------------------------------
`include "running_max_xor_pair_core_macros.svh"

module rmxp_checker import rmxp_pkg::*; #(
  parameter int MaxEntries = 256
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input max_xor_t out_max_xor_i,
  input logic     out_overflow_i,
  input logic     out_is_last_i
);

  localparam int CntW = $clog2(MaxEntries + 4) + 1;
  localparam logic [CntW-1:0] MaxInFlight = CntW'(MaxEntries + 1);

  logic [CntW-1:0] inflight_q;
  logic            in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_beat && !out_beat) begin
      inflight_q <= inflight_q + CntW'(1);
    end else if (out_beat && !in_beat) begin
      inflight_q <= inflight_q - CntW'(1);
    end
  end

  `RMXP_ASSERT_NOW(a_no_result_without_item, out_valid_i, inflight_q != '0, "result without input")
  `RMXP_ASSERT_NOW(a_inflight_bound, 1'b1, inflight_q <= MaxInFlight, "too many beats in flight")
  `RMXP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_max_xor_i) && $stable(out_overflow_i) && $stable(out_is_last_i), "stalled result changed")

endmodule

bind running_max_xor_pair_core rmxp_checker #(
  .MaxEntries(MAX_ENTRIES)
) u_rmxp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_max_xor_i (out_o.max_xor),
  .out_overflow_i(out_o.overflow),
  .out_is_last_i (out_o.is_last)
);
